// ----- rtl/core/stk_pkg.sv -----
// ----------------------------------------------------------------------------
// Streaming top-k select package
// Shared constants for the configuration port and the control type for the selection cells.
// ----------------------------------------------------------------------------
package stk_pkg;

  // Configuration port geometry: one 32-bit register at byte address zero.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam int KEEP_BITS = 5;

  // Register index, taken from address bit 2.
  localparam logic [0:0] REG_KEEP_COUNT = 1'b0;

  localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd10;

  // Per-cell control, computed once in the top level for every cell.
  typedef struct packed {
    logic en;         // a request is accepted this cycle
    logic occupied;   // this cell holds a ranked entry
    logic in_window;  // this cell lies below the effective keep count
  } cell_ctrl_t;

endpackage

// ----- rtl/core/streaming_top_k_select_top.sv -----
// ----------------------------------------------------------------------------
// Streaming top-k select, top level
// Latency: a query's first result is offered the cycle after its last score
//   is accepted; results then follow one per cycle while taken.
// Throughput: one score per cycle. A last score waits while the previous
//   query's drain is busy, unless its final result is taken in that cycle.
// Reset: fill count, position counter and drain empty; keep_count to 10.
// ----------------------------------------------------------------------------
module streaming_top_k_select_top #(
  parameter int MAX_KEEP      = 16,
  parameter int SCORE_BITS    = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Score requests. s_tdata: score. s_tlast: final_item.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((SCORE_BITS+7)/8)*8-1:0]   s_tdata,
  input  logic                              s_tlast,
  // Ranked results. m_tdata, lowest bit up: rank, doc_position, best_score.
  // m_tlast: run_end.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [(((MAX_KEEP > 1 ? $clog2(MAX_KEEP) : 1) + POSITION_BITS
                  + SCORE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                              m_tlast,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stk_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [stk_pkg::DATA_BITS-1:0]     pwdata,
  output logic [stk_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);

  localparam int FILL_BITS = $clog2(MAX_KEEP + 1);
  localparam int RANK_BITS = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int OUT_BITS  = RANK_BITS + POSITION_BITS + SCORE_BITS;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int KB        = stk_pkg::KEEP_BITS;

  // ---------------------------------------------------------------------------
  // Configuration register. Register index is address bit 2; reads return
  // zero for any index other than keep_count.
  // ---------------------------------------------------------------------------
  logic [KB-1:0] keep_count;
  logic          cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2:2] == stk_pkg::REG_KEEP_COUNT);
  assign prdata  = cfg_hit ? {{(stk_pkg::DATA_BITS-KB){1'b0}}, keep_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= stk_pkg::KEEP_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      keep_count <= pwdata[KB-1:0];
    end
  end

  // Effective keep count: zero acts as one, and anything above the cell
  // count is held to the cell count.
  logic [FILL_BITS-1:0] limit;

  always_comb begin
    if (keep_count == '0) begin
      limit = FILL_BITS'(1);
    end else if (32'(keep_count) > 32'(MAX_KEEP)) begin
      limit = FILL_BITS'(MAX_KEEP);
    end else begin
      limit = FILL_BITS'(keep_count);
    end
  end

  // ---------------------------------------------------------------------------
  // Fill count and position counter. A lowered keep count drops the tail of
  // the list before the new score is placed.
  // ---------------------------------------------------------------------------
  logic [FILL_BITS-1:0]     fill;
  logic [FILL_BITS-1:0]     fill_clamped;
  logic [FILL_BITS-1:0]     fill_next;
  logic [POSITION_BITS-1:0] pos_count;
  logic                     accept;
  logic                     drain_free;

  assign fill_clamped = (fill > limit) ? limit : fill;
  assign fill_next    = (fill_clamped < limit) ? fill_clamped + FILL_BITS'(1)
                                               : fill_clamped;

  // Only a last score needs the drain; ordinary scores are always taken.
  assign s_tready = drain_free || !s_tlast;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      pos_count <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        fill      <= '0;
        pos_count <= '0;
      end else begin
        fill <= fill_next;
        if (pos_count != '1) begin
          pos_count <= pos_count + POSITION_BITS'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row of selection cells. Each cell compares its entry with the new score
  // locally; a cell whose upper neighbor still ranks at or above the new
  // score takes the new entry, and the cells below it shift down by one.
  // ---------------------------------------------------------------------------
  logic signed [SCORE_BITS-1:0]    new_score;
  logic signed [SCORE_BITS-1:0]    c_score      [MAX_KEEP];
  logic signed [SCORE_BITS-1:0]    c_score_next [MAX_KEEP];
  logic        [POSITION_BITS-1:0] c_pos        [MAX_KEEP];
  logic        [POSITION_BITS-1:0] c_pos_next   [MAX_KEEP];
  logic                            c_ge         [MAX_KEEP];

  assign new_score = s_tdata[SCORE_BITS-1:0];

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    stk_pkg::cell_ctrl_t             ctrl;
    logic signed [SCORE_BITS-1:0]    up_score;
    logic        [POSITION_BITS-1:0] up_pos;
    logic                            up_ge;

    assign ctrl.en        = accept;
    assign ctrl.occupied  = (FILL_BITS'(i) < fill_clamped);
    assign ctrl.in_window = (FILL_BITS'(i) < limit);

    if (i == 0) begin : g_head
      assign up_score = new_score;
      assign up_pos   = pos_count;
      assign up_ge    = 1'b1;
    end else begin : g_body
      assign up_score = c_score[i-1];
      assign up_pos   = c_pos[i-1];
      assign up_ge    = c_ge[i-1];
    end

    stk_cell #(
      .SCORE_BITS    (SCORE_BITS),
      .POSITION_BITS (POSITION_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_score  (new_score),
      .new_pos    (pos_count),
      .prev_score (up_score),
      .prev_pos   (up_pos),
      .prev_ge    (up_ge),
      .score      (c_score[i]),
      .pos        (c_pos[i]),
      .ge         (c_ge[i]),
      .score_next (c_score_next[i]),
      .pos_next   (c_pos_next[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Output drain. The list as it stands after the last score is copied in
  // the same cycle, so the cells are free for the next query at once.
  // ---------------------------------------------------------------------------
  logic signed [SCORE_BITS-1:0]    head_score;
  logic        [POSITION_BITS-1:0] head_pos;
  logic        [RANK_BITS-1:0]     head_rank;

  stk_drain #(
    .MAX_KEEP      (MAX_KEEP),
    .SCORE_BITS    (SCORE_BITS),
    .POSITION_BITS (POSITION_BITS),
    .FILL_BITS     (FILL_BITS),
    .RANK_BITS     (RANK_BITS)
  ) u_drain (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && s_tlast),
    .load_count (fill_next),
    .load_score (c_score_next),
    .load_pos   (c_pos_next),
    .pop        (m_tready),
    .valid      (m_tvalid),
    .free       (drain_free),
    .head_score (head_score),
    .head_pos   (head_pos),
    .rank       (head_rank),
    .last       (m_tlast)
  );

  assign m_tdata = {{(OUT_W-OUT_BITS){1'b0}}, head_score, head_pos, head_rank};

endmodule

// ----- rtl/core/stk_cell.sv -----
// ----------------------------------------------------------------------------
// Selection cell
// Holds one ranked entry; compares against the new score and either keeps its
// entry, takes the new one, or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module stk_cell #(
  parameter int SCORE_BITS    = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                            clk,
  input  stk_pkg::cell_ctrl_t             ctrl,
  input  logic signed [SCORE_BITS-1:0]    new_score,
  input  logic        [POSITION_BITS-1:0] new_pos,
  input  logic signed [SCORE_BITS-1:0]    prev_score,
  input  logic        [POSITION_BITS-1:0] prev_pos,
  input  logic                            prev_ge,
  output logic signed [SCORE_BITS-1:0]    score,
  output logic        [POSITION_BITS-1:0] pos,
  output logic                            ge,
  output logic signed [SCORE_BITS-1:0]    score_next,
  output logic        [POSITION_BITS-1:0] pos_next
);

  // Equal held scores stay ahead of the new one.
  assign ge = ctrl.occupied && (score >= new_score);

  always_comb begin
    score_next = score;
    pos_next   = pos;
    if (ctrl.in_window && !ge) begin
      if (prev_ge) begin
        score_next = new_score;
        pos_next   = new_pos;
      end else begin
        score_next = prev_score;
        pos_next   = prev_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      score <= score_next;
      pos   <= pos_next;
    end
  end

endmodule

// ----- rtl/core/stk_drain.sv -----
// ----------------------------------------------------------------------------
// Output drain
// Snapshot of the ranked list that shifts toward the output one entry per
// accepted result, so a new query can fill the cells meanwhile.
// ----------------------------------------------------------------------------
module stk_drain #(
  parameter int MAX_KEEP      = 16,
  parameter int SCORE_BITS    = 32,
  parameter int POSITION_BITS = 16,
  parameter int FILL_BITS     = 5,
  parameter int RANK_BITS     = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic        [FILL_BITS-1:0]     load_count,
  input  logic signed [SCORE_BITS-1:0]    load_score [MAX_KEEP],
  input  logic        [POSITION_BITS-1:0] load_pos   [MAX_KEEP],
  input  logic                            pop,
  output logic                            valid,
  output logic                            free,
  output logic signed [SCORE_BITS-1:0]    head_score,
  output logic        [POSITION_BITS-1:0] head_pos,
  output logic        [RANK_BITS-1:0]     rank,
  output logic                            last
);

  logic signed [SCORE_BITS-1:0]    ent_score [MAX_KEEP];
  logic        [POSITION_BITS-1:0] ent_pos   [MAX_KEEP];
  logic        [FILL_BITS-1:0]     left;

  assign valid      = (left != '0);
  assign last       = (left == FILL_BITS'(1));
  assign free       = !valid || (last && pop);
  assign head_score = ent_score[0];
  assign head_pos   = ent_pos[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      rank <= '0;
    end else if (load) begin
      left <= load_count;
      rank <= '0;
    end else if (pop && valid) begin
      left <= left - FILL_BITS'(1);
      rank <= rank + RANK_BITS'(1);
    end
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_ent
    always_ff @(posedge clk) begin
      if (load) begin
        ent_score[i] <= load_score[i];
        ent_pos[i]   <= load_pos[i];
      end else if (pop && valid) begin
        if (i + 1 < MAX_KEEP) begin
          ent_score[i] <= ent_score[(i + 1) % MAX_KEEP];
          ent_pos[i]   <= ent_pos[(i + 1) % MAX_KEEP];
        end
      end
    end
  end

endmodule

// ----- rtl/core/stk_checker.sv -----
// ----------------------------------------------------------------------------
// Streaming top-k select port checker
// Watches the stream ports of the top level: holding and ordering of ranked results, and acceptance of ordinary scores.
// ----------------------------------------------------------------------------
module stk_checker #(
  parameter int RANK_BITS = 4,
  parameter int OUT_W     = 56
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tlast,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  logic [RANK_BITS-1:0] rank;

  assign rank = m_tdata[RANK_BITS-1:0];

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Results of one query come without gaps and with rising rank.
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (rank == $past(rank) + RANK_BITS'(1)))
    else $error("result run broken or rank out of order");

  // The result after a run end, if any, opens a new run at rank zero.
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || (rank == '0))
    else $error("new run does not start at rank zero");

  // Scores that do not end a query are never held back.
  a_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tlast |-> s_tready)
    else $error("ordinary score stalled");

endmodule

bind streaming_top_k_select_top stk_checker #(
  .RANK_BITS (RANK_BITS),
  .OUT_W     (OUT_W)
) u_stk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- sim/streaming_top_k_select_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Streaming top-k select testbench
// Streams signed Q1.30 scores into the selector and predicts the ranked
// entries of every query. Each emitted entry is checked field by field.
// keep_count is changed between phases, including its extreme and clamped
// values. The sender and the receiver pause at random, phase by phase.
// ----------------------------------------------------------------------------
module streaming_top_k_select_top_test;

  // Layout of m_tdata from the lowest bit up: rank, doc_position, best_score.
  localparam int RANK_LSB  = 0;
  localparam int POS_LSB   = 4;
  localparam int SCORE_LSB = 20;
  localparam int CELLS     = 16;

  // The keep_count register sits at byte address zero.
  localparam logic [stk_pkg::ADDR_BITS-1:0] KEEP_ADDR = {stk_pkg::REG_KEEP_COUNT, 2'b00};

  // Cycles to let pass after the last expected entry before the register is touched.
  localparam int SETTLE_CYCLES = 4;

  // Scores used by the directed queries.
  localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SCORE_MIN = 32'h8000_0000;
  localparam logic [31:0] SCORE_ZERO = 32'h0000_0000;
  localparam logic [31:0] SCORE_NEG_ONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]  rank;
    logic [15:0] doc_pos;
    logic [31:0] score;
    logic        run_end;
  } ranked_entry_t;

  // Keeps its own copy of the ranked list and the position counter, and
  // queues the entries that each closing score is going to release.
  class ranking_board;
    logic signed [31:0] held_score [CELLS];
    logic [15:0]        held_pos [CELLS];
    int                 fill;
    logic [15:0]        next_pos;
    logic [4:0]         keep_reg;
    ranked_entry_t      pending_entries [$];
    int                 errors;
    int                 scores_seen;
    int                 entries_checked;
    int                 queries_closed;

    function new();
      fill = 0;
      next_pos = '0;
      keep_reg = stk_pkg::KEEP_RESET;
      errors = 0;
      scores_seen = 0;
      entries_checked = 0;
      queries_closed = 0;
    endfunction

    function void set_keep(logic [4:0] value);
      keep_reg = value;
    endfunction

    // Zero behaves as one, and anything above the cell count as the cell count.
    function int keep_window();
      if (keep_reg == 0) return 1;
      if (keep_reg > CELLS) return CELLS;
      return keep_reg;
    endfunction

    function void note_score(logic signed [31:0] sc, logic lst);
      int limit;
      int last_slot;
      int slot;
      int i;
      ranked_entry_t entry;
      limit = keep_window();
      scores_seen++;
      // A lowered keep_count drops the tail before the new score is ranked.
      if (fill > limit) fill = limit;
      if (fill >= limit) begin
        last_slot = (sc > held_score[limit-1]) ? limit - 1 : -1;
      end else begin
        last_slot = fill;
        fill++;
      end
      if (last_slot >= 0) begin
        slot = 0;
        while (slot < last_slot && held_score[slot] >= sc) slot++;
        for (i = last_slot; i > slot; i--) begin
          held_score[i] = held_score[i-1];
          held_pos[i] = held_pos[i-1];
        end
        held_score[slot] = sc;
        held_pos[slot] = next_pos;
      end
      if (next_pos != 16'hFFFF) next_pos++;
      if (lst) begin
        for (i = 0; i < fill; i++) begin
          entry.rank = i[3:0];
          entry.doc_pos = held_pos[i];
          entry.score = held_score[i];
          entry.run_end = (i == fill - 1);
          pending_entries = {pending_entries, entry};
        end
        fill = 0;
        next_pos = '0;
        queries_closed++;
      end
    endfunction

    function void check_entry(ranked_entry_t got);
      ranked_entry_t want;
      if (pending_entries.size() == 0) begin
        errors++;
        $display("%0t: entry with none expected: rank %0d pos %0d score %0d last %0b",
                 $time, got.rank, got.doc_pos, $signed(got.score), got.run_end);
        return;
      end
      want = pending_entries.pop_front();
      entries_checked++;
      if (got.rank != want.rank) begin
        errors++;
        $display("%0t: rank expected %0d actual %0d", $time, want.rank, got.rank);
      end
      if (got.doc_pos != want.doc_pos) begin
        errors++;
        $display("%0t: doc_position expected %0d actual %0d (rank %0d)",
                 $time, want.doc_pos, got.doc_pos, want.rank);
      end
      if (got.score != want.score) begin
        errors++;
        $display("%0t: best_score expected %0d actual %0d (rank %0d)",
                 $time, $signed(want.score), $signed(got.score), want.rank);
      end
      if (got.run_end != want.run_end) begin
        errors++;
        $display("%0t: run_end expected %0b actual %0b (rank %0d)",
                 $time, want.run_end, got.run_end, want.rank);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // score
  logic        s_tlast = 1'b0; // final_item

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // rank, doc_position, best_score
  logic        m_tlast;        // run_end

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [stk_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [stk_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [stk_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  // Percentages of cycles in which the sender holds back or the receiver
  // refuses an entry. The main sequence changes them phase by phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int keep_settings = 0;

  ranking_board board = new();

  streaming_top_k_select_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides afresh every cycle whether it takes an entry.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both handshakes are sampled at the edge, before this edge's updates land.
  // A closing score and the tail of the previous query's drain can meet at
  // the same edge; the expected entries are kept in order, so either is fine.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_score(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        board.check_entry('{rank: m_tdata[RANK_LSB +: 4], doc_pos: m_tdata[POS_LSB +: 16],
                            score: m_tdata[SCORE_LSB +: 32], run_end: m_tlast});
      end
    end
  end

  // Offers one score, after a random pause, and returns once it was taken.
  // The valid stays high on return so that back-to-back requests need no
  // second assignment in the same step; callers that stop sending lower it.
  task automatic send_score(input logic [31:0] sc, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= sc;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // that closes the access cycle. The select is dropped again after each access.
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= KEEP_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Changes keep_count only once the block is idle: no score offered, every
  // expected entry delivered, and a further wait of SETTLE_CYCLES for the cell row to settle.
  // The value is read back afterwards.
  task automatic set_keep(input logic [4:0] value);
    logic [31:0] rd;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, {27'd0, value}, rd);
    board.set_keep(value);
    keep_settings++;
    apb_access(1'b0, '0, rd);
    if (rd != {27'd0, value}) begin
      board.errors++;
      $display("%0t: keep_count read expected %0d actual %0d", $time, value, rd);
    end
  endtask

  // Mostly full-range scores; a good share from a narrow band around zero so
  // that ties are frequent, and now and then one of the extremes.
  function automatic logic [31:0] pick_score();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return SCORE_MAX;
          1: return SCORE_MIN;
          2: return SCORE_ZERO;
          default: return SCORE_NEG_ONE;
        endcase
      end
      1, 2, 3: return 32'($signed($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  // Whole queries with random lengths until about the given number of scores
  // has gone in. Short queries dominate, so short-stream cases come up often.
  task automatic run_queries(input int n_scores);
    int sent;
    int len;
    int i;
    sent = 0;
    while (sent < n_scores) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
      for (i = 0; i < len; i++) send_score(pick_score(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin : timeout_guard
    #2000000;
    $display("FAIL streaming_top_k_select_top");
    $finish;
  end

  initial begin : main_sequence
    int i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no pauses. First query runs at the reset keep_count of
    // ten with both extremes, zero, minus one and a run of equal scores.
    send_score(SCORE_MAX, 1'b0);
    send_score(SCORE_MIN, 1'b0);
    send_score(SCORE_ZERO, 1'b0);
    send_score(SCORE_NEG_ONE, 1'b0);
    send_score(32'd5, 1'b0);
    send_score(32'd5, 1'b1);

    // Keep four: equal scores while filling, then equal and larger ones once
    // full, where an equal score must not enter but a larger one must.
    set_keep(5'd4);
    send_score(32'd7, 1'b0);
    send_score(32'd7, 1'b0);
    send_score(32'd3, 1'b0);
    send_score(32'd7, 1'b0);
    send_score(32'd3, 1'b0);
    send_score(32'd9, 1'b0);
    send_score(SCORE_MIN, 1'b1);

    // Zero acts as one; a single score that is also the last one.
    set_keep(5'd0);
    send_score(SCORE_NEG_ONE, 1'b1);
    send_score(32'd1, 1'b0);
    send_score(32'd2, 1'b1);

    // Above the cell count it acts as sixteen; a stream shorter than that.
    set_keep(5'd31);
    send_score(32'd11, 1'b0);
    send_score(SCORE_MAX, 1'b1);

    // keep_count lowered in the middle of a query drops the tail entries.
    set_keep(5'd16);
    for (i = 0; i < 6; i++) send_score(32'(i * 3), 1'b0);
    set_keep(5'd3);
    send_score(32'd4, 1'b0);
    send_score(32'd1, 1'b1);

    // Random phases: no pauses, sender pausing, receiver stalling, then both.
    set_keep(5'd1);
    run_queries(56);

    send_idle_pct = 59;
    set_keep(5'd16);
    run_queries(56);

    send_idle_pct = 0;
    recv_stall_pct = 59;
    set_keep(5'($urandom_range(31)));
    run_queries(56);

    send_idle_pct = 31;
    recv_stall_pct = 31;
    set_keep(5'($urandom_range(15, 2)));
    run_queries(56);
    s_tvalid <= 1'b0;

    // Drain, then keep watching for a while so that any stray entries show.
    @(posedge clk);
    while (board.pending_entries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d scores in %0d queries under %0d keep_count settings,",
             board.scores_seen, board.queries_closed, keep_settings);
    $display("with sender pauses and receiver stalls; %0d ranked entries were checked.",
             board.entries_checked);
    if (board.errors == 0) begin
      $display("PASS streaming_top_k_select_top");
    end else begin
      $display("FAIL streaming_top_k_select_top");
    end
    $finish;
  end

endmodule
